// ===== hdl/sfcc_pkg.sv =====
// Shared types, constants and functions for the sensor frame CRC and conversion block.
// It has no dependencies. sfcc_convert and sensor_frame_crc_convert use it.
package sfcc_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [13:0] HumScale   = 14'd12500;
  localparam logic [15:0] RoundBias  = 16'd32767;
  localparam logic [15:0] Divisor    = 16'd65535;
  localparam logic [15:0] TempOffset = 16'd4500;
  localparam logic [13:0] HumOffset  = 14'd600;
  localparam logic [13:0] HumMax     = 14'd10000;
  localparam logic [13:0] HumUpper   = 14'd10600;  // HumMax plus HumOffset

  // Status bits of one result.
  localparam int unsigned StatFirstBad  = 0;
  localparam int unsigned StatSecondBad = 1;

  // Kind of frame selected by the configuration register.
  typedef enum logic {
    KIND_MEASURE = 1'b0,
    KIND_SERIAL  = 1'b1
  } frame_kind_e;

  // Values produced from the two data words of one frame.
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               humidity_saturated;
    logic [31:0]        serial_number;
  } conv_result_t;

  // One byte through CRC-8, MSB first, no final xor.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Quotient of x by 65535. Taking x >> 16 as a first guess leaves a remainder of
  // x[15:0] plus that guess, which stays below twice the divisor while the guess
  // is below 65535, so one compare fixes the quotient.
  function automatic logic [15:0] div_by_65535(input logic [31:0] x);
    logic [15:0] q0;
    logic [16:0] r0;
    q0 = x[31:16];
    r0 = {1'b0, x[15:0]} + {1'b0, q0};
    if (r0 >= {1'b0, Divisor}) begin
      return q0 + 16'd1;
    end else begin
      return q0;
    end
  endfunction

endpackage

// ===== hdl/sfcc_convert.sv =====
// Conversion of the two data words of a frame into temperature, humidity or serial number.
// Depends on sfcc_pkg for the scale constants, the division helper and the result type.
module sfcc_convert (
  input  logic [15:0]           first_word_i,
  input  logic [15:0]           second_word_i,
  input  sfcc_pkg::frame_kind_e frame_kind_i,
  output sfcc_pkg::conv_result_t result_o
);

  logic [31:0] temp_scaled;
  logic [31:0] hum_scaled;
  logic [15:0] temp_quot;
  logic [15:0] hum_quot;
  logic [15:0] temp_value;
  logic [13:0] hum_value;
  logic        hum_sat;

  // Scaled and rounded values; both sums stay below 2^31.
  assign temp_scaled = ({17'd0, sfcc_pkg::TempScale} * {16'd0, first_word_i})
                     + {16'd0, sfcc_pkg::RoundBias};
  assign hum_scaled  = ({18'd0, sfcc_pkg::HumScale} * {16'd0, second_word_i})
                     + {16'd0, sfcc_pkg::RoundBias};

  assign temp_quot  = sfcc_pkg::div_by_65535(temp_scaled);
  assign hum_quot   = sfcc_pkg::div_by_65535(hum_scaled);
  assign temp_value = temp_quot - sfcc_pkg::TempOffset;

  // The humidity quotient is at most 12500, so its low 14 bits hold it.
  always_comb begin
    hum_value = '0;
    hum_sat   = 1'b0;
    priority if (hum_quot[13:0] < sfcc_pkg::HumOffset) begin
      hum_value = '0;
      hum_sat   = 1'b1;
    end else if (hum_quot[13:0] > sfcc_pkg::HumUpper) begin
      hum_value = sfcc_pkg::HumMax;
      hum_sat   = 1'b1;
    end else begin
      hum_value = hum_quot[13:0] - sfcc_pkg::HumOffset;
    end
  end

  always_comb begin
    result_o = '0;
    unique case (frame_kind_i)
      sfcc_pkg::KIND_SERIAL: begin
        result_o.serial_number = {first_word_i, second_word_i};
      end
      sfcc_pkg::KIND_MEASURE: begin
        result_o.temperature_centi  = temp_value[14:0];
        result_o.humidity_centi     = hum_value;
        result_o.humidity_saturated = hum_sat;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/sensor_frame_crc_convert.sv =====
// Top level of the sensor reply frame checker and converter.
// Depends on sfcc_pkg and instantiates sfcc_convert.
//
// Usage:
// The input channel carries one reply byte per transaction, in the order
// first word high, first word low, first CRC, second word high, second word
// low, second CRC. A byte with frame_start_i high always begins a new frame;
// a partial frame is then dropped without a result. Each word is checked
// with CRC-8 (polynomial 0x31, initial value 0xFF, MSB first).
// The sixth byte of a frame yields one output transaction in the cycle after
// it is accepted. It carries the CRC status, the raw words and either the
// converted temperature and humidity or the 32-bit serial number, as chosen
// by the frame kind register. The other bytes yield no output.
// Throughput is one byte per cycle while in_stall_o is low. The per-byte
// CRC and the constant-scaled conversion are done in the single logic stage
// between the frame state registers and the output register.
// When the receiver stalls while a result is held, in_stall_o rises in the
// same cycle and no byte is taken until the output register is free again;
// a result being taken frees the register for a new one in that cycle.
// Reset clears the frame position, the CRC state, the frame kind (to
// measurement) and the output valid flag.
// The frame kind register may be written only while no frame is in flight.
module sensor_frame_crc_convert (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic               humidity_saturated_o,
  output logic [31:0]        serial_number_o,
  output logic [15:0]        first_word_o,
  output logic [15:0]        second_word_o
);

  // Position of the next byte within the frame.
  typedef enum logic [2:0] {
    POS_W1_HI  = 3'd0,
    POS_W1_LO  = 3'd1,
    POS_W1_CRC = 3'd2,
    POS_W2_HI  = 3'd3,
    POS_W2_LO  = 3'd4,
    POS_W2_CRC = 3'd5
  } pos_e;

  sfcc_pkg::frame_kind_e frame_kind_q;
  pos_e                  pos_q, pos_d, pos_cur;
  logic [7:0]            crc_q, crc_d;
  logic [15:0]           acc_q, acc_d;
  logic [15:0]           held_q, held_d;
  logic                  first_bad_q, first_bad_d;
  logic                  in_accept;
  logic                  frame_done;
  logic                  second_bad;
  logic                  out_valid_q;
  sfcc_pkg::conv_result_t conv;

  // The byte is taken unless a held result is being stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // A frame start forces the first position.
  assign pos_cur = frame_start_i ? POS_W1_HI : pos_q;

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    acc_d       = acc_q;
    held_d      = held_q;
    first_bad_d = first_bad_q;
    frame_done  = 1'b0;
    second_bad  = (crc_q != data_byte_i);
    unique case (pos_cur)
      POS_W1_HI, POS_W2_HI: begin
        crc_d = sfcc_pkg::crc8_byte(sfcc_pkg::CrcInit, data_byte_i);
        acc_d = {data_byte_i, 8'd0};
        pos_d = (pos_cur == POS_W1_HI) ? POS_W1_LO : POS_W2_LO;
      end
      POS_W1_LO, POS_W2_LO: begin
        crc_d = sfcc_pkg::crc8_byte(crc_q, data_byte_i);
        acc_d = acc_q | {8'd0, data_byte_i};
        pos_d = (pos_cur == POS_W1_LO) ? POS_W1_CRC : POS_W2_CRC;
      end
      POS_W1_CRC: begin
        first_bad_d = (crc_q != data_byte_i);
        held_d      = acc_q;
        crc_d       = sfcc_pkg::CrcInit;
        pos_d       = POS_W2_HI;
      end
      POS_W2_CRC: begin
        crc_d      = sfcc_pkg::CrcInit;
        pos_d      = POS_W1_HI;
        frame_done = 1'b1;
      end
      default: begin
        // Unused position codes behave as the first byte of a frame.
        crc_d = sfcc_pkg::crc8_byte(sfcc_pkg::CrcInit, data_byte_i);
        acc_d = {data_byte_i, 8'd0};
        pos_d = POS_W1_LO;
      end
    endcase
  end

  sfcc_convert u_convert (
    .first_word_i  (held_q),
    .second_word_i (acc_q),
    .frame_kind_i  (frame_kind_q),
    .result_o      (conv)
  );

  // Configuration and frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_kind_q <= sfcc_pkg::KIND_MEASURE;
      pos_q        <= POS_W1_HI;
      crc_q        <= sfcc_pkg::CrcInit;
      acc_q        <= '0;
      held_q       <= '0;
      first_bad_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_kind_q <= sfcc_pkg::frame_kind_e'(cfg_wdata_i);
      end
      if (in_accept) begin
        pos_q       <= pos_d;
        crc_q       <= crc_d;
        acc_q       <= acc_d;
        held_q      <= held_d;
        first_bad_q <= first_bad_d;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && frame_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; loaded only when a frame completes.
  always_ff @(posedge clk_i) begin
    if (in_accept && frame_done) begin
      status_o[sfcc_pkg::StatFirstBad]  <= first_bad_q;
      status_o[sfcc_pkg::StatSecondBad] <= second_bad;
      temperature_centi_o  <= conv.temperature_centi;
      humidity_centi_o     <= conv.humidity_centi;
      humidity_saturated_o <= conv.humidity_saturated;
      serial_number_o      <= conv.serial_number;
      first_word_o         <= held_q;
      second_word_o        <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/sfcc_checker.sv =====
// Port-level checks for sensor_frame_crc_convert, attached by a bind statement.
// Depends only on the ports of the top level.
module sfcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic signed [14:0] temperature_centi_o,
  input logic [13:0]        humidity_centi_o,
  input logic               humidity_saturated_o,
  input logic [15:0]        first_word_o,
  input logic [15:0]        second_word_o
);

  // Input is held back only while a result waits on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
      && $stable(first_word_o) && $stable(second_word_o)))
    else $error("stalled result changed");

  // A clamped humidity sits at one of its limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && humidity_saturated_o) |->
      (humidity_centi_o == 14'd0 || humidity_centi_o == 14'd10000))
    else $error("saturated humidity not at a limit");

  // Converted values stay inside their ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (humidity_centi_o <= 14'd10000
      && temperature_centi_o >= -15'sd4500 && temperature_centi_o <= 15'sd13000))
    else $error("converted value out of range");

endmodule

bind sensor_frame_crc_convert sfcc_checker u_sfcc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .status_o             (status_o),
  .temperature_centi_o  (temperature_centi_o),
  .humidity_centi_o     (humidity_centi_o),
  .humidity_saturated_o (humidity_saturated_o),
  .first_word_o         (first_word_o),
  .second_word_o        (second_word_o)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for sensor_frame_crc_convert: reply frames, CRC status,
// conversion and serial mode, checked against an in-bench frame decoder.
// Depends on sfcc_pkg and the RTL of sensor_frame_crc_convert.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // CRC-8 seed and generator of the sensor reply words.
  localparam logic [7:0] CrcSeed = 8'hFF;
  localparam logic [7:0] CrcGen  = 8'h31;

  // Fixed-point conversion terms; gains, offsets and the ceiling are in hundredths.
  localparam longint TempGain  = 17500;
  localparam longint HumGain   = 12500;
  localparam longint RoundAdd  = 32767;
  localparam longint FullScale = 65535;
  localparam longint TempShift = 4500;
  localparam longint HumShift  = 600;
  localparam longint HumCeil   = 10000;

  // The result is registered in the cycle after the sixth byte, so settling
  // for SettleCycles covers any work still in flight before a register write.
  localparam int SettleCycles  = 8;
  localparam int LongHold      = 400;
  localparam int WatchdogLimit = 3000;
  localparam int PhaseItems    = 315;
  localparam int PhaseCount    = 6;

  // One reply byte as offered on the input channel.
  typedef struct packed {
    logic [7:0] value;
    logic       start;
  } reply_byte_t;

  // Everything the block reports for one complete frame.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [14:0] temperature;
    logic [13:0]        humidity;
    logic               saturated;
    logic [31:0]        serial;
    logic [15:0]        word_a;
    logic [15:0]        word_b;
  } frame_reading_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Stimulus side of the block, all known from time zero.
  logic       cfg_we      = 1'b0;
  logic       cfg_wdata   = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] data_byte   = 8'h00;
  logic       frame_start = 1'b0;
  logic       out_stall   = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic signed [14:0] temperature_centi_o;
  logic [13:0]        humidity_centi_o;
  logic               humidity_saturated_o;
  logic [31:0]        serial_number_o;
  logic [15:0]        first_word_o;
  logic [15:0]        second_word_o;

  // Bytes waiting to be offered, and readings waiting to come out.
  reply_byte_t    pending_bytes[$];
  frame_reading_t awaited_readings[$];

  // Decoder state: the bench's own copy of the frame tracking registers.
  sfcc_pkg::frame_kind_e kind_cfg = sfcc_pkg::KIND_MEASURE;
  logic [2:0]  frame_pos   = 3'd0;
  logic [7:0]  crc_acc     = CrcSeed;
  logic [15:0] word_acc    = 16'h0000;
  logic [15:0] held_word   = 16'h0000;
  logic        first_bad   = 1'b0;

  // Pacing knobs that the stimulus sequence sets per phase.
  int unsigned gap_max    = 0;
  int unsigned stall_pct  = 0;
  bit          hold_req   = 1'b0;
  bit          hold_taken = 1'b0;

  int unsigned gap_left    = 0;
  int unsigned burst_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned run_left    = 0;
  bit          run_stall   = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;

  sensor_frame_crc_convert DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall_o),
    .data_byte_i          (data_byte),
    .frame_start_i        (frame_start),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall),
    .status_o             (status_o),
    .temperature_centi_o  (temperature_centi_o),
    .humidity_centi_o     (humidity_centi_o),
    .humidity_saturated_o (humidity_saturated_o),
    .serial_number_o      (serial_number_o),
    .first_word_o         (first_word_o),
    .second_word_o        (second_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // CRC-8 over one byte, MSB first, no final inversion.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcGen) : (c << 1);
    end
    return c;
  endfunction

  // Advances the frame decoder by one accepted byte. Returns 1 when the byte
  // closes a frame, with the reading that the block must report for it.
  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output frame_reading_t r);
    logic [2:0] p;
    logic       second_bad;
    longint     temp, hum;
    r = '0;
    // A start byte always opens a new frame; a partial one is dropped.
    if (start) begin
      frame_pos = 3'd0;
    end
    p = (frame_pos > 3'd5) ? 3'd0 : frame_pos;
    case (p)
      3'd0, 3'd3: begin
        crc_acc   = crc8_next(CrcSeed, b);
        word_acc  = {b, 8'h00};
        frame_pos = p + 3'd1;
        return 1'b0;
      end
      3'd1, 3'd4: begin
        crc_acc       = crc8_next(crc_acc, b);
        word_acc[7:0] = b;
        frame_pos     = p + 3'd1;
        return 1'b0;
      end
      3'd2: begin
        first_bad = (crc_acc != b);
        held_word = word_acc;
        crc_acc   = CrcSeed;
        frame_pos = 3'd3;
        return 1'b0;
      end
      default: begin
        second_bad = (crc_acc != b);
        frame_pos  = 3'd0;
        crc_acc    = CrcSeed;
        r.status[sfcc_pkg::StatFirstBad]  = first_bad;
        r.status[sfcc_pkg::StatSecondBad] = second_bad;
        r.word_a = held_word;
        r.word_b = word_acc;
        if (kind_cfg == sfcc_pkg::KIND_SERIAL) begin
          r.serial = {held_word, word_acc};
        end else begin
          // Bad CRCs do not stop the conversion; only the status tells.
          temp = (TempGain * held_word + RoundAdd) / FullScale - TempShift;
          hum  = (HumGain * word_acc + RoundAdd) / FullScale - HumShift;
          if (hum < 0) begin
            hum         = 0;
            r.saturated = 1'b1;
          end else if (hum > HumCeil) begin
            hum         = HumCeil;
            r.saturated = 1'b1;
          end
          r.temperature = temp[14:0];
          r.humidity    = hum[13:0];
        end
        return 1'b1;
      end
    endcase
  endfunction

  // Queues one six-byte frame. Set bits of corrupt spoil the CRC of the
  // matching word so that the status reports it.
  task automatic queue_frame(input logic [15:0] w1, input logic [15:0] w2,
                             input logic [1:0] corrupt, input logic start);
    logic [7:0] c1, c2;
    c1 = crc8_next(crc8_next(CrcSeed, w1[15:8]), w1[7:0]);
    c2 = crc8_next(crc8_next(CrcSeed, w2[15:8]), w2[7:0]);
    if (corrupt[sfcc_pkg::StatFirstBad]) c1 = c1 ^ 8'($urandom_range(1, 255));
    if (corrupt[sfcc_pkg::StatSecondBad]) c2 = c2 ^ 8'($urandom_range(1, 255));
    pending_bytes.push_back('{w1[15:8], start});
    pending_bytes.push_back('{w1[7:0], 1'b0});
    pending_bytes.push_back('{c1, 1'b0});
    pending_bytes.push_back('{w2[15:8], 1'b0});
    pending_bytes.push_back('{w2[7:0], 1'b0});
    pending_bytes.push_back('{c2, 1'b0});
  endtask

  // Queues the first len bytes of a random frame, opened by a start byte.
  task automatic queue_partial(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      pending_bytes.push_back('{8'($urandom_range(0, 255)), (k == 0)});
    end
  endtask

  // Mostly random words, with the scale ends now and then.
  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // One phase of random traffic. Most of it is well-formed frames with random
  // words and occasional bad CRCs; the rest is cut-off frames and loose bytes.
  // The phase always closes on a complete frame so that no frame is left open
  // when the register is written next.
  task automatic queue_phase(input int unsigned n_items);
    int unsigned added, pick, len;
    bit          need_start;
    logic [1:0]  corrupt;
    added      = 0;
    need_start = 1'b1;
    while (added < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        corrupt = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
        // Without a start bit the frame follows on by wrap-around alone.
        queue_frame(pick_word(), pick_word(), corrupt,
                    need_start || ($urandom_range(0, 3) != 0));
        added      += 6;
        need_start  = 1'b0;
      end else if (pick < 90) begin
        len = $urandom_range(1, 5);
        queue_partial(len);
        added      += len;
        need_start  = 1'b1;
      end else begin
        len = $urandom_range(1, 8);
        for (int unsigned k = 0; k < len; k++) begin
          pending_bytes.push_back('{8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0)});
        end
        added      += len;
        need_start  = 1'b1;
      end
    end
    queue_frame(pick_word(), pick_word(), 2'b00, 1'b1);
  endtask

  // Waits until every byte has gone in and every reading has come out, then
  // lets the block settle. Checked at the falling edge to stay clear of the
  // clocked processes.
  task automatic drain();
    while (!(pending_bytes.size() == 0 && !in_valid && awaited_readings.size() == 0)) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the frame kind register while the block is idle.
  task automatic set_kind(input sfcc_pkg::frame_kind_e k);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    kind_cfg   = k;
  endtask

  task automatic check_field(input string name, input logic signed [32:0] want,
                             input logic signed [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Sender: offers queued bytes, in bursts of random length with random gaps
  // if gap_max is set. A stalled transaction keeps its payload until taken.
  always @(posedge clk_i) begin : sender
    reply_byte_t    nxt;
    frame_reading_t r;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        if (decode_byte(data_byte, frame_start, r)) begin
          awaited_readings.push_back(r);
        end
      end
      if (!(in_valid && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          nxt = pending_bytes.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= nxt.value;
          frame_start <= nxt.start;
          if (gap_max > 0) begin
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(1, gap_max);
            end else begin
              burst_left--;
            end
          end
        end
      end
    end
  end

  // Receiver: stalls in runs of random length, and once holds off for a
  // long stretch so that the output register fills and the input stalls.
  always @(posedge clk_i) begin : receiver
    if (hold_req && !hold_taken) begin
      hold_left  = LongHold;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_stall = ($urandom_range(0, 99) < stall_pct);
        run_left  = $urandom_range(1, 8);
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  // Monitor: every output transaction must match the oldest awaited reading.
  always @(posedge clk_i) begin : monitor
    frame_reading_t exp_r;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (awaited_readings.size() == 0) begin
        $error("output transaction with no reading awaited");
        error_count++;
      end else begin
        exp_r = awaited_readings.pop_front();
        check_field("status", exp_r.status, status_o);
        check_field("temperature_centi", exp_r.temperature, temperature_centi_o);
        check_field("humidity_centi", exp_r.humidity, humidity_centi_o);
        check_field("humidity_saturated", exp_r.saturated, humidity_saturated_o);
        check_field("serial_number", exp_r.serial, serial_number_o);
        check_field("first_word", exp_r.word_a, first_word_o);
        check_field("second_word", exp_r.word_b, second_word_o);
      end
    end
  end

  // Watchdog: a run in which nothing moves on either channel for too long
  // is hung.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : sequence_main
    sfcc_pkg::frame_kind_e k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed measurement frames: both scale ends (humidity clamped low and
    // high), a bad first CRC, a frame cut short by a new start byte, and a
    // bad second CRC.
    set_kind(sfcc_pkg::KIND_MEASURE);
    @(negedge clk_i);
    queue_frame(16'h0000, 16'h0000, 2'b00, 1'b1);
    queue_frame(16'hFFFF, 16'hFFFF, 2'b01, 1'b1);
    queue_partial(3);
    queue_frame(16'hABCD, 16'h0F0F, 2'b10, 1'b1);
    drain();

    // Directed serial frame with both CRCs bad, following on from the last
    // frame without a start bit.
    set_kind(sfcc_pkg::KIND_SERIAL);
    @(negedge clk_i);
    queue_frame(16'hFFFF, 16'h0000, 2'b11, 1'b0);
    drain();

    // Random phases, alternating the frame kind. The first phase runs with no
    // idling at all; the second carries the long receiver hold-off while the
    // sender keeps offering. Between phases the sender pauses until every
    // reading has come out.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      k = (ph % 2 == 0) ? sfcc_pkg::KIND_SERIAL : sfcc_pkg::KIND_MEASURE;
      set_kind(k);
      @(negedge clk_i);
      if (ph == 0) begin
        gap_max   = 0;
        stall_pct = 0;
      end else if (ph == 1) begin
        gap_max   = 0;
        stall_pct = 30;
        hold_req  = 1'b1;
      end else begin
        gap_max   = $urandom_range(1, 6);
        stall_pct = $urandom_range(10, 60);
      end
      queue_phase(PhaseItems);
      drain();
    end

    if (error_count == 0 && awaited_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
